>>> hw/rtl/okn_pkg.sv
// Package for the octree key neighbor finder.
// Holds the shared constants, the job record passed from front to back,
// and the axis interleave function. Depends on nothing.
package okn_pkg;

    localparam int KEY_WIDTH   = 64;
    localparam int MAX_LEVELS  = 21;
    localparam int COORD_W     = MAX_LEVELS;
    localparam int POS_W       = 7;
    localparam int DEPTH_W     = $clog2(MAX_LEVELS + 1);
    localparam int GROUP_N     = (KEY_WIDTH + 7) / 8;
    localparam int NUM_SLOTS   = 26;
    localparam int SLOT_W      = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Reciprocal of three for values below 128.
    localparam int DIV3_MUL    = 43;
    localparam int DIV3_SHIFT  = 7;

    typedef logic [1:0] step_t;
    localparam step_t STEP_BACK  = 2'd0;
    localparam step_t STEP_STILL = 2'd1;
    localparam step_t STEP_FWD   = 2'd2;

    localparam int AXIS_Z = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_X = 2;

    typedef struct packed {
        logic                 bad;
        logic                 oct_mode;
        logic [2:0]           octant;
        logic [KEY_WIDTH-1:0] flag;
        logic [COORD_W-1:0]   cx;
        logic [COORD_W-1:0]   cy;
        logic [COORD_W-1:0]   cz;
        logic [COORD_W-1:0]   unit;
    } job_t;

    // The coordinate is kept left aligned: its top bit is the coarsest level,
    // which sits in the lowest bit group of the key.
    function automatic logic [KEY_WIDTH-1:0] spread_axis(input logic [COORD_W-1:0] c,
                                                         input int axis);
        logic [KEY_WIDTH-1:0] k;
        k = '0;
        for (int j = 0; j < COORD_W; j++) begin
            if (3 * j + axis < KEY_WIDTH) begin
                k[3 * j + axis] = c[COORD_W - 1 - j];
            end
        end
        return k;
    endfunction

endpackage

>>> hw/rtl/okn_front.sv
// Front part of the octree key neighbor finder: accepts a cube key, locates
// its flag bit in two steps with a register between them and builds a job record.
// Depends on okn_pkg.
module okn_front import okn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [63:0]          s_cube_key,
    output logic                 push_valid,
    input  logic                 push_ready,
    output job_t                 push_job
);

    logic                 a_valid_reg;
    logic [KEY_WIDTH-1:0] a_key_reg;
    logic [GROUP_N-1:0]   a_nz_reg;
    logic [2:0]           a_pos_reg [GROUP_N];

    logic [GROUP_N-1:0]   grp_nz;
    logic [2:0]           grp_pos [GROUP_N];

    logic                    found;
    logic [POS_W-1:0]        pos;
    logic [POS_W+6-1:0]      prod;
    logic [DEPTH_W-1:0]      depth;
    logic [POS_W-1:0]        rem;
    logic [DEPTH_W:0]        unit_sh;
    logic [KEY_WIDTH-1:0]    flag;
    logic [KEY_WIDTH-1:0]    body;
    logic                    accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !a_valid_reg || push_ready;

    always_comb begin
        for (int g = 0; g < GROUP_N; g++) begin
            grp_nz[g]  = 1'b0;
            grp_pos[g] = 3'd0;
            for (int b = 0; b < 8; b++) begin
                if (g * 8 + b < KEY_WIDTH) begin
                    if (s_cube_key[g * 8 + b]) begin
                        grp_nz[g]  = 1'b1;
                        grp_pos[g] = 3'(b);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (push_ready) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_key_reg <= s_cube_key[KEY_WIDTH-1:0];
            a_nz_reg  <= grp_nz;
            for (int g = 0; g < GROUP_N; g++) begin
                a_pos_reg[g] <= grp_pos[g];
            end
        end
    end

    always_comb begin
        found = 1'b0;
        pos   = '0;
        for (int g = 0; g < GROUP_N; g++) begin
            if (a_nz_reg[g]) begin
                found = 1'b1;
                pos   = POS_W'(g * 8) + POS_W'(a_pos_reg[g]);
            end
        end
        prod    = (POS_W+6)'(pos) * (POS_W+6)'(DIV3_MUL);
        depth   = DEPTH_W'(prod >> DIV3_SHIFT);
        rem     = pos - POS_W'(3 * depth);
        flag    = KEY_WIDTH'(1) << pos;
        body    = a_key_reg & ~flag;
        unit_sh = (DEPTH_W+1)'(COORD_W) - {1'b0, depth};

        push_job.bad      = !found || (depth == '0) || (rem != '0)
                            || (depth > DEPTH_W'(MAX_LEVELS));
        push_job.oct_mode = (depth == DEPTH_W'(1));
        push_job.octant   = a_key_reg[2:0];
        push_job.flag     = flag;
        push_job.unit     = COORD_W'(1) << unit_sh;
        push_job.cx       = '0;
        push_job.cy       = '0;
        push_job.cz       = '0;
        for (int j = 0; j < COORD_W; j++) begin
            if (3 * j + AXIS_Z < KEY_WIDTH) begin
                push_job.cz[COORD_W - 1 - j] = body[3 * j + AXIS_Z];
            end
            if (3 * j + AXIS_Y < KEY_WIDTH) begin
                push_job.cy[COORD_W - 1 - j] = body[3 * j + AXIS_Y];
            end
            if (3 * j + AXIS_X < KEY_WIDTH) begin
                push_job.cx[COORD_W - 1 - j] = body[3 * j + AXIS_X];
            end
        end
    end

    assign push_valid = a_valid_reg;

endmodule

>>> hw/rtl/okn_queue.sv
// Short job queue between the front and back parts of the octree key
// neighbor finder, so that each side can stall on its own.
// Depends on okn_pkg.
module okn_queue import okn_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + QCNT_W'(1)))
        else $error("Queue count did not follow a push.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Empty queue has unequal pointers.");

endmodule

>>> hw/rtl/okn_back.sv
// Back part of the octree key neighbor finder: walks the 26 neighbor slots of
// one job, one slot per cycle while the result channel accepts, into a registered result stage.
// Depends on okn_pkg.
module okn_back import okn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 faces_edges_only,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  job_t                 pop_job,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [63:0]          m_neighbor_key,
    output logic [4:0]           m_neighbor_slot,
    output logic                 m_key_invalid,
    output logic                 m_last
);

    logic              active_reg;
    job_t              job_reg;
    logic [SLOT_W-1:0] slot_reg;
    step_t             xs_reg, ys_reg, zs_reg;
    step_t             xs_next, ys_next, zs_next;

    logic                 m_valid_reg;
    logic [63:0]          m_key_reg;
    logic [SLOT_W-1:0]    m_slot_reg;
    logic                 m_invalid_reg;
    logic                 m_last_reg;

    logic                 adv;
    logic                 last_slot;
    logic                 do_pop;
    logic                 corner;
    logic [COORD_W-1:0]   px, py, pz;
    logic [2:0]           oct_code;
    logic [KEY_WIDTH-1:0] slot_key;

    assign adv       = active_reg && (!m_valid_reg || m_ready);
    assign last_slot = (slot_reg == SLOT_W'(NUM_SLOTS - 1));
    assign pop_ready = !active_reg || (adv && last_slot);
    assign do_pop    = pop_valid && pop_ready;

    function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] c,
                                                      input logic [COORD_W-1:0] u,
                                                      input step_t s);
        logic [COORD_W-1:0] r;
        unique case (s)
            STEP_BACK: r = c - u;
            STEP_FWD:  r = c + u;
            default:   r = c;
        endcase
        return r;
    endfunction

    always_comb begin
        zs_next = zs_reg;
        ys_next = ys_reg;
        xs_next = xs_reg;
        if (zs_reg == STEP_FWD) begin
            zs_next = STEP_BACK;
            if (ys_reg == STEP_FWD) begin
                ys_next = STEP_BACK;
                xs_next = xs_reg + step_t'(1);
            end else begin
                ys_next = ys_reg + step_t'(1);
            end
        end else begin
            zs_next = zs_reg + step_t'(1);
        end
        if (xs_next == STEP_STILL && ys_next == STEP_STILL && zs_next == STEP_STILL) begin
            zs_next = STEP_FWD;
        end
    end

    always_comb begin
        corner   = (xs_reg != STEP_STILL) && (ys_reg != STEP_STILL)
                   && (zs_reg != STEP_STILL);
        px       = step_coord(job_reg.cx, job_reg.unit, xs_reg);
        py       = step_coord(job_reg.cy, job_reg.unit, ys_reg);
        pz       = step_coord(job_reg.cz, job_reg.unit, zs_reg);
        oct_code = job_reg.octant + slot_reg[2:0] + 3'd1;
        if (job_reg.bad || (faces_edges_only && corner)) begin
            slot_key = '0;
        end else if (job_reg.oct_mode) begin
            slot_key = (slot_reg < SLOT_W'(7))
                       ? (job_reg.flag | KEY_WIDTH'(oct_code)) : '0;
        end else begin
            slot_key = job_reg.flag | spread_axis(px, AXIS_X)
                       | spread_axis(py, AXIS_Y) | spread_axis(pz, AXIS_Z);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            slot_reg   <= '0;
            xs_reg     <= STEP_BACK;
            ys_reg     <= STEP_BACK;
            zs_reg     <= STEP_BACK;
        end else if (do_pop) begin
            active_reg <= 1'b1;
            slot_reg   <= '0;
            xs_reg     <= STEP_BACK;
            ys_reg     <= STEP_BACK;
            zs_reg     <= STEP_BACK;
        end else if (adv && last_slot) begin
            active_reg <= 1'b0;
        end else if (adv) begin
            slot_reg <= slot_reg + SLOT_W'(1);
            xs_reg   <= xs_next;
            ys_reg   <= ys_next;
            zs_reg   <= zs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_pop) begin
            job_reg <= pop_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_key_reg     <= 64'(slot_key);
            m_slot_reg    <= slot_reg;
            m_invalid_reg <= job_reg.bad;
            m_last_reg    <= last_slot;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_neighbor_key  = m_key_reg;
    assign m_neighbor_slot = m_slot_reg;
    assign m_key_invalid   = m_invalid_reg;
    assign m_last          = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (slot_reg <= SLOT_W'(NUM_SLOTS - 1)))
        else $error("Slot counter ran past the last neighbor.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_slot_reg == SLOT_W'(NUM_SLOTS - 1)))
        else $error("Last flag on a slot other than the final one.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && !last_slot) |=> (slot_reg == $past(slot_reg) + SLOT_W'(1)))
        else $error("Slot counter did not advance with a result.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> !(xs_reg == STEP_STILL && ys_reg == STEP_STILL
                         && zs_reg == STEP_STILL))
        else $error("Center cell reached by the slot walk.");

endmodule

>>> hw/rtl/octree_key_neighbors.sv
// Top level of the octree key neighbor finder: configuration register,
// front part, job queue and back part.
// Depends on okn_pkg, okn_front, okn_queue and okn_back.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_cube_key
//   m_        out        m_valid / m_ready    m_neighbor_key, m_neighbor_slot,
//                                             m_key_invalid, m_last
//   cfg_      in         cfg_valid / cfg_ready  cfg_data (faces_edges_only)
//
// Each key produces 26 result transactions, one per cycle while the result
// channel keeps up; the slot walk in the back part sets that rate, and the
// back part takes the next key only as it hands out the last slot of the current one.
// A key passes the front register, the job queue, the back job register and the result register.
// Reset is synchronous and active low and clears all control state.
// The job queue holds two keys, so the input side keeps running while the
// result channel is stalled until the queue fills.
module octree_key_neighbors import okn_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_cube_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_neighbor_key,
    output logic [4:0]  m_neighbor_slot,
    output logic        m_key_invalid,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    logic faces_edges_only_reg;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    job_t push_job, pop_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            faces_edges_only_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            faces_edges_only_reg <= cfg_data;
        end
    end

    okn_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_cube_key (s_cube_key),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    okn_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    okn_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .faces_edges_only (faces_edges_only_reg),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_job          (pop_job),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_neighbor_key   (m_neighbor_key),
        .m_neighbor_slot  (m_neighbor_slot),
        .m_key_invalid    (m_key_invalid),
        .m_last           (m_last)
    );

endmodule
